/* hdl/gvce_pkg.sv */
// Shared types, widths and fit coefficients for the Chapman-Enskog viscosity pipeline.
// No dependencies; every other file imports this package.
package gvce_pkg;

    typedef struct packed {
        logic [15:0] molar_mass;
        logic [15:0] well_depth;
        logic [13:0] diameter;
        logic [20:0] temperature;
    } t_item;

    typedef struct packed {
        logic [31:0] viscosity;
        logic        saturated;
    } t_result;

    // datapath widths
    localparam int MT_W   = 37;  // molar_mass * temperature
    localparam int RAD_W  = 62;  // sqrt radicand, padded to an even width
    localparam int S_W    = 31;  // sqrt(M*T) scaled by 2^12
    localparam int D1N_W  = 52;  // reduced temperature dividend
    localparam int D1D_W  = 21;  // reduced temperature divisor
    localparam int X_W    = 33;  // Tr or 1/Tr in Q32, up to 2^32
    localparam int ACC_W  = 32;  // Horner accumulator
    localparam int D2N_W  = 64;  // omega dividend
    localparam int OM_W   = 34;  // omega in Q32
    localparam int DD_W   = 28;  // diameter squared
    localparam int P_W    = 63;  // K8 * s
    localparam int NUM_W  = 75;  // K8 * s * 2^12
    localparam int DEN_W  = 62;  // diameter^2 * omega
    localparam int VIS_W  = 32;

    localparam logic [31:0]     VISC_K8   = 32'd2866428507;
    localparam logic [OM_W-1:0] OMEGA_MAX = '1;

    // sideband bundles carried alongside the arithmetic units
    typedef struct packed {
        logic [15:0] well_depth;
        logic [13:0] diameter;
        logic [20:0] temperature;
    } t_sq_sb;

    typedef struct packed {
        logic [S_W-1:0] s;
        logic [13:0]    diameter;
        logic           low_tr;     // Tr <= 1: evaluate in Tr, else in 1/Tr
        logic           wd_zero;    // well depth zero: force reduced value to 0
    } t_d1_sb;

    typedef struct packed {
        logic [S_W-1:0] s;
        logic [13:0]    diameter;
    } t_hn_sb;

    localparam int SQ_SB_W = $bits(t_sq_sb);
    localparam int D1_SB_W = $bits(t_d1_sb);
    localparam int HN_SB_W = $bits(t_hn_sb);

    // fit coefficients in Q28, rounded to nearest
    localparam logic [63:0] M1_Q =
        (64'd33530622607 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] M2_Q =
        (64'd253272006 * 64'd268435456 + 64'd50000000) / 64'd100000000;
    localparam logic [63:0] M3_Q =
        (64'd29024238575 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] M4_Q =
        (64'd11186138893 * 64'd268435456 + 64'd50000000000) / 64'd100000000000;
    localparam logic [63:0] M5_Q =
        (64'd8662326188 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] M6_Q =
        (64'd13913958626 * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] M7_Q =
        (64'd3158490576 * 64'd268435456 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] M8_Q =
        (64'd18973411754 * 64'd268435456 + 64'd50000000000) / 64'd100000000000;
    localparam logic [63:0] M9_Q =
        (64'd18682962894 * 64'd268435456 + 64'd50000000000000) / 64'd100000000000000;

    typedef logic [ACC_W-1:0] t_coef;

    // Horner order, leading coefficient first; numerator padded with a zero term
    localparam t_coef NUM_LO [0:4] = '{32'd0, M4_Q[31:0], M3_Q[31:0], M2_Q[31:0], M1_Q[31:0]};
    localparam t_coef DEN_LO [0:4] = '{M9_Q[31:0], M8_Q[31:0], M7_Q[31:0], M6_Q[31:0],
                                       M5_Q[31:0]};
    localparam t_coef NUM_HI [0:4] = '{32'd0, M1_Q[31:0], M2_Q[31:0], M3_Q[31:0], M4_Q[31:0]};
    localparam t_coef DEN_HI [0:4] = '{M5_Q[31:0], M6_Q[31:0], M7_Q[31:0], M8_Q[31:0],
                                       M9_Q[31:0]};

endpackage

/* hdl/gvce_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on gvce_pkg.
module gvce_sqrt import gvce_pkg::*; #(
    parameter int RW = RAD_W,
    parameter int SW = SQ_SB_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_rad,
    input  logic [SW-1:0]     i_sb,
    output logic              o_valid,
    output logic [RW/2-1:0]   o_root,
    output logic [SW-1:0]     o_sb
);
    localparam int QW = RW / 2;

    logic          r_v    [0:QW-1];
    logic [QW:0]   r_rem  [0:QW-1];
    logic [QW-1:0] r_root [0:QW-1];
    logic [RW-1:0] r_rad  [0:QW-1];
    logic [SW-1:0] r_sb   [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          v_in;
        logic [QW:0]   rem_in;
        logic [QW-1:0] root_in;
        logic [RW-1:0] rad_in;
        logic [SW-1:0] sb_in;
        logic [QW+2:0] rem2;
        logic [QW+2:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign sb_in   = r_sb[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem2  = {rem_in, rad_in[RW-1-2*k -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? (QW+1)'(rem2 - trial) : (QW+1)'(rem2);
            r_root[k] <= {root_in[QW-2:0], ge};
            r_rad[k]  <= rad_in;
            r_sb[k]   <= sb_in;
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_root  = r_root[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

/* hdl/gvce_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// Depends on gvce_pkg.
module gvce_div import gvce_pkg::*; #(
    parameter int NW = D1N_W,
    parameter int DW = D1D_W,
    parameter int QW = X_W,
    parameter int SW = D1_SB_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [SW-1:0] o_sb
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          r_v   [0:QW];
    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic [QW-1:0] r_lo  [0:QW];
    logic [DW-1:0] r_d   [0:QW];
    logic          r_ovf [0:QW];
    logic [SW-1:0] r_sb  [0:QW];

    logic [CW-1:0] hi_c;
    logic [CW-1:0] den_c;

    // quotient fits in QW bits only if the upper dividend part is below the divisor
    assign hi_c  = CW'(i_num[NW-1:QW]);
    assign den_c = CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(hi_c);
        r_q[0]   <= '0;
        r_lo[0]  <= i_num[QW-1:0];
        r_d[0]   <= i_den;
        r_ovf[0] <= (hi_c >= den_c);
        r_sb[0]  <= i_sb;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_st
        logic [DW:0] rem2;
        logic        ge;

        assign rem2 = {r_rem[k-1], r_lo[k-1][QW-k]};
        assign ge   = (rem2 >= {1'b0, r_d[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? DW'(rem2 - {1'b0, r_d[k-1]}) : DW'(rem2);
            r_q[k]   <= {r_q[k-1][QW-2:0], ge};
            r_lo[k]  <= r_lo[k-1];
            r_d[k]   <= r_d[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_sb[k]  <= r_sb[k-1];
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_sb    = r_sb[QW];

endmodule

/* hdl/gvce_horner.sv */
// Two-lane pipelined Horner evaluation of the collision-integral fit polynomials.
// Depends on gvce_pkg (coefficient tables and widths).
module gvce_horner import gvce_pkg::*; #(
    parameter int SW = HN_SB_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [X_W-1:0]   i_x,
    input  logic             i_low_tr,
    input  logic [SW-1:0]    i_sb,
    output logic             o_valid,
    output logic [ACC_W-1:0] o_num,
    output logic [ACC_W-1:0] o_den,
    output logic [X_W-1:0]   o_x,
    output logic             o_low_tr,
    output logic [SW-1:0]    o_sb
);
    localparam int NSTEP = 4;
    localparam int NST   = 2 * NSTEP + 1;
    localparam int PW    = ACC_W + X_W;

    logic             r_v   [0:NST-1];
    logic [X_W-1:0]   r_x   [0:NST-1];
    logic             r_lt  [0:NST-1];
    logic [SW-1:0]    r_sb  [0:NST-1];
    logic [ACC_W-1:0] r_an  [0:NSTEP];
    logic [ACC_W-1:0] r_ad  [0:NSTEP];
    logic [PW-1:0]    r_pn  [1:NSTEP];
    logic [PW-1:0]    r_pd  [1:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]  <= i_x;
        r_lt[0] <= i_low_tr;
        r_sb[0] <= i_sb;
        r_an[0] <= i_low_tr ? NUM_LO[0] : NUM_HI[0];
        r_ad[0] <= i_low_tr ? DEN_LO[0] : DEN_HI[0];
    end

    for (genvar j = 1; j < NST; j++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[j]  <= r_x[j-1];
            r_lt[j] <= r_lt[j-1];
            r_sb[j] <= r_sb[j-1];
        end
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        t_coef cn;
        t_coef cd;

        assign cn = r_lt[2*k-1] ? NUM_LO[k] : NUM_HI[k];
        assign cd = r_lt[2*k-1] ? DEN_LO[k] : DEN_HI[k];

        // multiply stage
        always_ff @(posedge i_clk) begin
            r_pn[k] <= PW'(r_an[k-1]) * PW'(r_x[2*k-2]);
            r_pd[k] <= PW'(r_ad[k-1]) * PW'(r_x[2*k-2]);
        end

        // scale back from Q32 and add the next coefficient
        always_ff @(posedge i_clk) begin
            r_an[k] <= ACC_W'(r_pn[k][PW-1:32] + (PW-32)'(cn));
            r_ad[k] <= ACC_W'(r_pd[k][PW-1:32] + (PW-32)'(cd));
        end
    end

    assign o_valid  = r_v[NST-1];
    assign o_num    = r_an[NSTEP];
    assign o_den    = r_ad[NSTEP];
    assign o_x      = r_x[NST-1];
    assign o_low_tr = r_lt[NST-1];
    assign o_sb     = r_sb[NST-1];

endmodule

/* hdl/gas_viscosity_chapman_enskog.sv */
// Top level of the dilute-gas viscosity pipeline (Chapman-Enskog, Lennard-Jones fit).
// Depends on gvce_pkg, gvce_sqrt, gvce_div and gvce_horner.
//
// Usage:
//   Input channel: drive i_item with one species record and raise start. The record
//   transfers at the rising edge where start is high and busy is low. busy never
//   rises: the pipeline takes a new record in every cycle.
//   Output channel: o_valid is high for exactly one cycle with the result on o_result;
//   that cycle's closing edge is the transfer. The receiver cannot hold results off,
//   and none is needed since no stage ever stalls.
//   Order: results transfer in the order of their records.
//   Throughput: one record per cycle. The pipeline is made of these units in series:
//   square root (31 stages), reduced temperature divider (34), Horner fit (9),
//   omega divider (35) and final quotient divider (33), plus six boundary registers.
//   Reset: synchronous, active low; it clears every valid bit so in-flight records are
//   dropped and no result follows. Payload registers are not reset.
//   Special inputs: zero diameter gives all ones with the saturated flag set; zero
//   temperature or zero mass gives zero.
module gas_viscosity_chapman_enskog import gvce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    // ---------------- entry and M*T product ----------------
    logic        r_v0;
    t_item       r_in;
    logic        r_v1;
    logic [MT_W-1:0] r_mt;
    t_sq_sb      r_sq_in;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
        r_mt <= MT_W'(r_in.molar_mass) * MT_W'(r_in.temperature);
        r_sq_in.well_depth  <= r_in.well_depth;
        r_sq_in.diameter    <= r_in.diameter;
        r_sq_in.temperature <= r_in.temperature;
    end

    // ---------------- sqrt(M*T * 2^24) ----------------
    logic           sq_v;
    logic [S_W-1:0] sq_root;
    logic [SQ_SB_W-1:0] sq_sb_raw;
    t_sq_sb         sq_sb;

    gvce_sqrt #(.RW(RAD_W), .SW(SQ_SB_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_rad   ({1'b0, r_mt, 24'd0}),
        .i_sb    (r_sq_in),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sb_raw)
    );

    assign sq_sb = t_sq_sb'(sq_sb_raw);

    // ---------------- reduced temperature, Tr or 1/Tr in Q32 ----------------
    logic               low_tr;
    logic [D1N_W-1:0]   d1_num;
    logic [D1D_W-1:0]   d1_den;
    t_d1_sb             d1_sb_in;
    logic               d1_v;
    logic [X_W-1:0]     d1_quo;
    logic               d1_ovf;
    logic [D1_SB_W-1:0] d1_sb_raw;
    t_d1_sb             d1_sb;
    logic [X_W-1:0]     x_red;
    t_hn_sb             hn_sb_in;

    // Tr <= 1 when temperature <= 16 * well_depth (1/256 K against 1/16 K)
    assign low_tr = (sq_sb.temperature <= {1'b0, sq_sb.well_depth, 4'd0});
    assign d1_num = low_tr ? D1N_W'({sq_sb.temperature, 28'd0})
                           : D1N_W'({sq_sb.well_depth, 36'd0});
    assign d1_den = low_tr ? D1D_W'(sq_sb.well_depth) : sq_sb.temperature;

    assign d1_sb_in.s        = sq_root;
    assign d1_sb_in.diameter = sq_sb.diameter;
    assign d1_sb_in.low_tr   = low_tr;
    assign d1_sb_in.wd_zero  = (sq_sb.well_depth == '0);

    gvce_div #(.NW(D1N_W), .DW(D1D_W), .QW(X_W), .SW(D1_SB_W)) u_div_tr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_sb    (d1_sb_in),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_ovf   (d1_ovf),
        .o_sb    (d1_sb_raw)
    );

    assign d1_sb = t_d1_sb'(d1_sb_raw);
    // zero well depth: only a divide by zero can overflow here; the value is 0
    assign x_red = (d1_sb.wd_zero || d1_ovf) ? '0 : d1_quo;

    assign hn_sb_in.s        = d1_sb.s;
    assign hn_sb_in.diameter = d1_sb.diameter;

    // ---------------- fit polynomials ----------------
    logic               hn_v;
    logic [ACC_W-1:0]   hn_num;
    logic [ACC_W-1:0]   hn_den;
    logic [X_W-1:0]     hn_x;
    logic               hn_low_tr;
    logic [HN_SB_W-1:0] hn_sb_raw;
    t_hn_sb             hn_sb;

    gvce_horner #(.SW(HN_SB_W)) u_horner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d1_v),
        .i_x      (x_red),
        .i_low_tr (d1_sb.low_tr),
        .i_sb     (hn_sb_in),
        .o_valid  (hn_v),
        .o_num    (hn_num),
        .o_den    (hn_den),
        .o_x      (hn_x),
        .o_low_tr (hn_low_tr),
        .o_sb     (hn_sb_raw)
    );

    assign hn_sb = t_hn_sb'(hn_sb_raw);

    // ---------------- omega dividend ----------------
    logic               r_vm;
    logic [D2N_W-1:0]   r_dvd;
    logic [ACC_W-1:0]   r_dvs;
    t_hn_sb             r_m_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= hn_v;
        end
    end

    // low Tr: num * 2^32; high Tr: the reversed fit needs one more factor of 1/Tr
    always_ff @(posedge i_clk) begin
        r_dvd  <= hn_low_tr ? {hn_num, 32'd0}
                            : D2N_W'(D2N_W'(hn_x[31:0]) * D2N_W'(hn_num));
        r_dvs  <= hn_den;
        r_m_sb <= hn_sb;
    end

    // ---------------- omega ----------------
    logic               d2_v;
    logic [OM_W-1:0]    d2_quo;
    logic               d2_ovf;
    logic [HN_SB_W-1:0] d2_sb_raw;
    t_hn_sb             d2_sb;
    logic [OM_W-1:0]    omega;

    gvce_div #(.NW(D2N_W), .DW(ACC_W), .QW(OM_W), .SW(HN_SB_W)) u_div_om (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vm),
        .i_num   (r_dvd),
        .i_den   (r_dvs),
        .i_sb    (r_m_sb),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_ovf   (d2_ovf),
        .o_sb    (d2_sb_raw)
    );

    assign d2_sb = t_hn_sb'(d2_sb_raw);
    // clamp omega to [1, max]
    assign omega = d2_ovf ? OMEGA_MAX : ((d2_quo == '0) ? OM_W'(1) : d2_quo);

    // ---------------- final numerator and denominator ----------------
    logic               r_vf1;
    logic [OM_W-1:0]    r_om;
    logic [DD_W-1:0]    r_dd;
    logic [P_W-1:0]     r_p;
    logic               r_vf2;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
            r_vf2 <= 1'b0;
        end else begin
            r_vf1 <= d2_v;
            r_vf2 <= r_vf1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_om  <= omega;
        r_dd  <= DD_W'(d2_sb.diameter) * DD_W'(d2_sb.diameter);
        r_p   <= P_W'(VISC_K8) * P_W'(d2_sb.s);
        r_den <= DEN_W'(r_dd) * DEN_W'(r_om);
        r_num <= {r_p, 12'd0};
    end

    // ---------------- viscosity quotient ----------------
    logic             d3_v;
    logic [VIS_W-1:0] d3_quo;
    logic             d3_ovf;
    logic             d3_sb;

    // zero diameter makes the divisor zero and lands in the overflow flag
    gvce_div #(.NW(NUM_W), .DW(DEN_W), .QW(VIS_W), .SW(1)) u_div_vis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vf2),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_sb    (1'b0),
        .o_valid (d3_v),
        .o_quo   (d3_quo),
        .o_ovf   (d3_ovf),
        .o_sb    (d3_sb)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.viscosity <= d3_ovf ? '1 : d3_quo;
        o_result.saturated <= d3_ovf | d3_sb;
    end

    // ---------------- assertions ----------------
    a_omega_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vf1 |-> (r_om != '0))
        else $error("omega reached the final stage as zero");

    a_zero_den_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vf2 && (r_den == '0)) |-> ##34 (o_valid && o_result.saturated))
        else $error("zero divisor did not produce a saturated result");

    a_out_follows_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vf2, 34))
        else $error("result strobe without a matching item in flight");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy rose");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##148 o_valid)
        else $error("pipeline dropped an item");

endmodule

/* tb/gas_viscosity_chapman_enskog_test.sv */
// Self-checking testbench for the Chapman-Enskog viscosity pipeline.
// Depends on gvce_pkg and gas_viscosity_chapman_enskog; predicts each result in the bench.
module gas_viscosity_chapman_enskog_test;
    import gvce_pkg::*;

    localparam int LATENCY  = 148;
    localparam int WATCHDOG = 4000;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_result visc_queue[$];
    int      mismatch_count;
    int      results_seen;
    int      idle_cycles;
    int      send_idle_pct;
    bit      timed_out;

    gas_viscosity_chapman_enskog u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Fit coefficients in Q28, rounded to nearest from the decimal constants.
    function automatic logic [63:0] q28(logic [63:0] n, logic [63:0] d);
        return (n * 64'd268435456 + d / 2) / d;
    endfunction

    // Evaluate a polynomial by Horner; c[0] is the leading coefficient.
    function automatic logic [63:0] horner_q32(logic [63:0] c[], logic [63:0] x);
        logic [127:0] acc;
        acc = c[0];
        for (int k = 1; k < c.size(); k++) begin
            acc = ((acc * x) >> 32) + c[k];
            acc = acc[63:0];
        end
        return acc[63:0];
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] collision_omega(logic [63:0] w, logic [63:0] t);
        logic [63:0]  m1, m2, m3, m4, m5, m6, m7, m8, m9;
        logic [63:0]  x, n, d;
        logic [127:0] om;
        logic [63:0]  cn[];
        logic [63:0]  cd[];
        m1 = q28(64'd33530622607, 64'd10000000000);
        m2 = q28(64'd253272006, 64'd100000000);
        m3 = q28(64'd29024238575, 64'd10000000000);
        m4 = q28(64'd11186138893, 64'd100000000000);
        m5 = q28(64'd8662326188, 64'd10000000000);
        m6 = q28(64'd13913958626, 64'd10000000000);
        m7 = q28(64'd3158490576, 64'd1000000000);
        m8 = q28(64'd18973411754, 64'd100000000000);
        m9 = q28(64'd18682962894, 64'd100000000000000);
        if (t <= 16 * w) begin
            // Evaluate in Tr.
            x  = (w == 0) ? 64'd0 : ((t << 28) / w);
            cn = '{m4, m3, m2, m1};
            cd = '{m9, m8, m7, m6, m5};
            n  = horner_q32(cn, x);
            d  = horner_q32(cd, x);
            om = ({64'd0, n} << 32) / d;
        end else begin
            // Evaluate the reversed fit in 1/Tr.
            x  = (w << 36) / t;
            cn = '{m1, m2, m3, m4};
            cd = '{m5, m6, m7, m8, m9};
            n  = horner_q32(cn, x);
            d  = horner_q32(cd, x);
            om = ({64'd0, x} * n) / d;
            om = om[63:0];
        end
        om = om[63:0];
        if (om < 1) om = 1;
        if (om > 128'h3_FFFF_FFFF) om = 128'h3_FFFF_FFFF;
        return om[63:0];
    endfunction

    function automatic t_result predict_viscosity(t_item it);
        t_result      r;
        logic [63:0]  s;
        logic [127:0] num, den, q;
        if (it.diameter == 0) begin
            r.viscosity = '1;
            r.saturated = 1'b1;
            return r;
        end
        s   = isqrt((64'(it.molar_mass) * 64'(it.temperature)) << 24);
        num = (128'(VISC_K8) * 128'(s)) << 12;
        den = 128'(it.diameter) * 128'(it.diameter)
            * 128'(collision_omega(64'(it.well_depth), 64'(it.temperature)));
        q   = num / den;
        if (q >= 128'h1_0000_0000) begin
            r.viscosity = '1;
            r.saturated = 1'b1;
        end else begin
            r.viscosity = q[31:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Transfer one record; start holds high while records follow back to back.
    task automatic send_record(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        visc_queue.push_back(predict_viscosity(it));
    endtask

    task automatic release_line();
        start <= 1'b0;
    endtask

    function automatic t_item random_record();
        t_item it;
        it.molar_mass  = 16'($urandom);
        it.well_depth  = 16'($urandom);
        it.diameter    = 14'($urandom);
        it.temperature = 21'($urandom);
        case ($urandom_range(5))
            0: it.temperature = 21'($urandom_range(65535));
            1: it.temperature = 21'(it.well_depth) * 21'd16 + 21'($urandom_range(3)) - 21'd1;
            2: it.diameter    = 14'($urandom_range(16383, 8000));
            3: it.well_depth  = 16'($urandom_range(4095, 1));
            default: ;
        endcase
        return it;
    endfunction

    task automatic test_directed();
        t_item it;
        t_item cases[$];
        cases.push_back('{16'd1, 16'd1, 14'd1, 21'd0});             // zero temperature
        cases.push_back('{16'd0, 16'd500, 14'd3000, 21'd70000});    // zero mass
        cases.push_back('{16'd500, 16'd500, 14'd0, 21'd70000});     // zero diameter
        cases.push_back('{16'd500, 16'd0, 14'd3000, 21'd70000});    // zero well depth
        cases.push_back('{16'hFFFF, 16'hFFFF, 14'h3FFF, 21'h1FFFFF});
        cases.push_back('{16'd1, 16'hFFFF, 14'h3FFF, 21'd1});
        cases.push_back('{16'hFFFF, 16'd1, 14'd1, 21'h1FFFFF});
        cases.push_back('{16'd1024, 16'd1000, 14'd3500, 21'd256000}); // Tr = 16
        cases.push_back('{16'd1024, 16'd1000, 14'd3500, 21'd256001});
        cases.push_back('{16'd7168, 16'd1600, 14'd3800, 21'd76800});
        cases.push_back('{16'd2, 16'd2, 14'd16383, 21'd1});
        cases.push_back('{16'hFFFF, 16'd1, 14'd16383, 21'd16});
        cases.push_back('{16'h5555, 16'hAAAA, 14'h2AAA, 21'h155555});
        cases.push_back('{16'hAAAA, 16'h5555, 14'h1555, 21'h0AAAAA});
        foreach (cases[i]) begin
            it = cases[i];
            send_record(it);
        end
        release_line();
    endtask

    task automatic test_random_phase(int pct, int count);
        send_idle_pct = pct;
        for (int i = 0; i < count; i++) send_record(random_record());
        release_line();
    endtask

    // Check each result against the oldest prediction as it transfers.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (visc_queue.size() == 0) begin
                report_mismatch("unexpected result", o_result.viscosity, 32'd0);
            end else begin
                t_result want;
                want = visc_queue.pop_front();
                if (o_result.viscosity !== want.viscosity)
                    report_mismatch("viscosity", o_result.viscosity, want.viscosity);
                if (o_result.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_result.saturated),
                                    32'(want.saturated));
            end
        end
    end

    // Count cycles with no transfer in either direction; end the run at the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer in %0d cycles", WATCHDOG);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int drain;
        mismatch_count = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        timed_out      = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        // The receiver cannot stall, so only sender idling varies between phases.
        test_random_phase(0, 300);
        test_random_phase(87, 150);
        test_random_phase(24, 200);
        test_random_phase(0, 200);

        drain = 0;
        while (visc_queue.size() != 0 && drain < 4 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (visc_queue.size() != 0)
            report_mismatch("results left over", 32'(visc_queue.size()), 32'd0);

        $display("covered %0d results: edge records, Tr near 1, zero inputs, random idling",
                 results_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
